/* design/rs_pkg.sv */
`timescale 1ns / 1ps
// rs_pkg: shared types and constants of the reservoir sampler
// no dependencies

package rs_pkg;

  localparam int DATA_W = 32;
  localparam int SIZE_W = 7;
  localparam int SLOT_W = 6;
  localparam int MODE_W = 2;
  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(DATA_W - 1);
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd16;

  localparam logic [MODE_W-1:0] MODE_OFFER   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

  typedef struct packed {
    logic capture;
    logic seen_inc;
    logic seen_clr;
    logic div_start;
    logic div_slot;
    logic wr_fill;
    logic wr_rand;
    logic rd_init;
    logic rd_issue;
    logic rd_next;
    logic emit_fill;
    logic emit_rand;
    logic emit_reject;
    logic emit_rd;
    logic emit_empty;
  } rs_cmd_t;

  typedef struct packed {
    logic fill;
    logic div_done;
    logic win;
    logic seen_zero;
    logic rd_last;
  } rs_sts_t;

endpackage

/* design/reservoir_sampler.sv */
`timescale 1ns / 1ps
// reservoir_sampler: top level joining controller and datapath
// depends on rs_pkg, rs_ctrl, rs_dp
//
// channel   direction  handshake             payload
// command   in         start & !busy         mode_i, item_value_i, random_word_i, random_slot_i
// result    out        strobe_o, one cycle   accepted_o, slot_o, value_o, last_o, empty_res_o
// config    in         cfg_we_i              cfg_wdata_i (sample_size)
//
// offer while filling: written from the check state without the divider; later offers run the shared 32-step divider,
// once when rejected and twice when accepted (the second division picks the slot)
// read out: an address state and an output state per result, limited by the registered memory read
// restart and empty read out complete from idle; reset clears the count, the sample size goes to 16
// results are strobed in the cycle after they are formed and cannot be stalled

module reservoir_sampler #(
  parameter int CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [rs_pkg::MODE_W-1:0]  mode_i,
  input  logic [rs_pkg::DATA_W-1:0]  item_value_i,
  input  logic [rs_pkg::DATA_W-1:0]  random_word_i,
  input  logic [rs_pkg::DATA_W-1:0]  random_slot_i,
  input  logic                       cfg_we_i,
  input  logic [rs_pkg::SIZE_W-1:0]  cfg_wdata_i,
  output logic                       strobe_o,
  output logic                       accepted_o,
  output logic [rs_pkg::SLOT_W-1:0]  slot_o,
  output logic [rs_pkg::DATA_W-1:0]  value_o,
  output logic                       last_o,
  output logic                       empty_res_o
);
  import rs_pkg::*;

  rs_cmd_t cmd;
  rs_sts_t sts;
  logic    busy_int;

  rs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mode_i  (mode_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_int)
  );

  rs_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .item_value_i  (item_value_i),
    .random_word_i (random_word_i),
    .random_slot_i (random_slot_i),
    .strobe_o      (strobe_o),
    .accepted_o    (accepted_o),
    .slot_o        (slot_o),
    .value_o       (value_o),
    .last_o        (last_o),
    .empty_res_o   (empty_res_o)
  );

  assign busy = busy_int;

endmodule

/* design/rs_div.sv */
`timescale 1ns / 1ps
// rs_div: iterative restoring divider, one dividend bit per cycle
// depends on rs_pkg

module rs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rs_pkg::DATA_W-1:0]  dividend_i,
  input  logic [rs_pkg::DATA_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [rs_pkg::DATA_W-1:0]  rem_o
);
  import rs_pkg::*;

  logic [DATA_W-1:0] rem_q, rem_d, dq_q, dvs_q;
  logic [STEP_W-1:0] cnt_q;
  logic              run_q, done_q;
  logic [DATA_W:0]   trial, diff;

  always_comb begin
    trial = {rem_q, dq_q[DATA_W-1]};
    diff  = trial - {1'b0, dvs_q};
    rem_d = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_LAST_STEP) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      dq_q  <= {dq_q[DATA_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* design/rs_dp.sv */
`timescale 1ns / 1ps
// rs_dp: datapath with seen count, sample memory, divider and result registers
// depends on rs_pkg and rs_div

module rs_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rs_pkg::rs_cmd_t            cmd_i,
  output rs_pkg::rs_sts_t            sts_o,
  input  logic                       cfg_we_i,
  input  logic [rs_pkg::SIZE_W-1:0]  cfg_wdata_i,
  input  logic [rs_pkg::DATA_W-1:0]  item_value_i,
  input  logic [rs_pkg::DATA_W-1:0]  random_word_i,
  input  logic [rs_pkg::DATA_W-1:0]  random_slot_i,
  output logic                       strobe_o,
  output logic                       accepted_o,
  output logic [rs_pkg::SLOT_W-1:0]  slot_o,
  output logic [rs_pkg::DATA_W-1:0]  value_o,
  output logic                       last_o,
  output logic                       empty_res_o
);
  import rs_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [SIZE_W-1:0] CAP_K = SIZE_W'(CAPACITY);

  logic [SIZE_W-1:0] size_q, k, f;
  logic [DATA_W-1:0] seen_q, k_ext, item_q, rword_q, rslot_q;
  logic [DATA_W-1:0] div_a, div_b, div_rem;
  logic              div_done;
  logic [SIZE_W-1:0] rd_cnt_q;
  logic [DATA_W-1:0] store_q [CAPACITY];
  logic [DATA_W-1:0] rd_data_q;
  logic [SLOT_W-1:0] fill_slot, rand_slot;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic              strobe_q, acc_q, last_q, empty_q;
  logic [SLOT_W-1:0] slot_q;
  logic [DATA_W-1:0] value_q;

  // effective sample size clamped to 1..capacity
  always_comb begin
    if (size_q == '0) begin
      k = SIZE_W'(1);
    end else if (size_q > CAP_K) begin
      k = CAP_K;
    end else begin
      k = size_q;
    end
    k_ext = {{(DATA_W-SIZE_W){1'b0}}, k};
    f     = (seen_q < k_ext) ? seen_q[SIZE_W-1:0] : k;
    fill_slot = SLOT_W'(seen_q - 32'd1);
    rand_slot = div_rem[SLOT_W-1:0];
    div_a = cmd_i.div_slot ? rslot_q : rword_q;
    div_b = cmd_i.div_slot ? k_ext : seen_q;
    wr_en = cmd_i.wr_fill | cmd_i.wr_rand;
    wr_idx = cmd_i.wr_rand ? rand_slot[IDX_W-1:0] : fill_slot[IDX_W-1:0];
  end

  always_comb begin
    sts_o.fill      = (seen_q <= k_ext);
    sts_o.div_done  = div_done;
    sts_o.win       = (div_rem < k_ext);
    sts_o.seen_zero = (seen_q == '0);
    sts_o.rd_last   = ((rd_cnt_q + 1'b1) == f);
  end

  rs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= SIZE_RESET;
      seen_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (cmd_i.seen_clr) begin
        seen_q <= '0;
      end else if (cmd_i.seen_inc && (seen_q != '1)) begin
        seen_q <= seen_q + 1'b1;
      end
      strobe_q <= cmd_i.emit_fill | cmd_i.emit_rand | cmd_i.emit_reject |
                  cmd_i.emit_rd | cmd_i.emit_empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q  <= item_value_i;
      rword_q <= random_word_i;
      rslot_q <= random_slot_i;
    end
    if (cmd_i.rd_init) begin
      rd_cnt_q <= '0;
    end else if (cmd_i.rd_next) begin
      rd_cnt_q <= rd_cnt_q + 1'b1;
    end
  end

  // sample memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= item_q;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= store_q[rd_cnt_q[IDX_W-1:0]];
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_fill || cmd_i.emit_rand) begin
      acc_q   <= 1'b1;
      slot_q  <= cmd_i.emit_rand ? rand_slot : fill_slot;
      value_q <= '0;
      last_q  <= 1'b0;
      empty_q <= 1'b0;
    end else if (cmd_i.emit_reject) begin
      acc_q   <= 1'b0;
      slot_q  <= '0;
      value_q <= '0;
      last_q  <= 1'b0;
      empty_q <= 1'b0;
    end else if (cmd_i.emit_rd) begin
      acc_q   <= 1'b0;
      slot_q  <= rd_cnt_q[SLOT_W-1:0];
      value_q <= rd_data_q;
      last_q  <= sts_o.rd_last;
      empty_q <= 1'b0;
    end else if (cmd_i.emit_empty) begin
      acc_q   <= 1'b0;
      slot_q  <= '0;
      value_q <= '0;
      last_q  <= 1'b1;
      empty_q <= 1'b1;
    end
  end

  assign strobe_o    = strobe_q;
  assign accepted_o  = acc_q;
  assign slot_o      = slot_q;
  assign value_o     = value_q;
  assign last_o      = last_q;
  assign empty_res_o = empty_q;

endmodule

/* design/rs_ctrl.sv */
`timescale 1ns / 1ps
// rs_ctrl: controller state machine sequencing offer, read out and restart
// depends on rs_pkg

module rs_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rs_pkg::MODE_W-1:0]  mode_i,
  input  rs_pkg::rs_sts_t            sts_i,
  output rs_pkg::rs_cmd_t            cmd_o,
  output logic                       busy_o
);
  import rs_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_DIV     = 3'd2;
  localparam logic [2:0] ST_SLOT    = 3'd3;
  localparam logic [2:0] ST_RD_ADDR = 3'd4;
  localparam logic [2:0] ST_RD_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          case (mode_i)
            MODE_OFFER: begin
              cmd_o.seen_inc = 1'b1;
              state_d = ST_CHECK;
            end
            MODE_READ: begin
              if (sts_i.seen_zero) begin
                cmd_o.emit_empty = 1'b1;
              end else begin
                cmd_o.rd_init = 1'b1;
                state_d = ST_RD_ADDR;
              end
            end
            MODE_RESTART: begin
              cmd_o.seen_clr = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (sts_i.fill) begin
          cmd_o.wr_fill   = 1'b1;
          cmd_o.emit_fill = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          if (sts_i.win) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_slot  = 1'b1;
            state_d = ST_SLOT;
          end else begin
            cmd_o.emit_reject = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_SLOT: begin
        if (sts_i.div_done) begin
          cmd_o.wr_rand   = 1'b1;
          cmd_o.emit_rand = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RD_ADDR: begin
        cmd_o.rd_issue = 1'b1;
        state_d = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        cmd_o.emit_rd = 1'b1;
        if (sts_i.rd_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.rd_next = 1'b1;
          state_d = ST_RD_ADDR;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule
